FILE: rtl/cpra_pkg.sv
// Shared types, codes and constants of the contiguous page run allocator.
package cpra_pkg;

  localparam int PAGES_DEF = 1024;
  localparam int PN_W      = 11;  // page counts, page numbers and the break
  localparam int IDX_W     = 10;  // page index field of a request
  localparam int EW        = 12;  // page map entry
  localparam int ADDR_W    = 3;   // APB byte address
  localparam int DATA_W    = 32;

  localparam logic [EW-1:0]     CONT_MARK   = '1;
  localparam logic [PN_W-1:0]   LIMIT_RESET = 11'd1024;
  localparam logic              REG_LIMIT   = 1'b0;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;
  localparam logic [1:0] ST_ZERO    = 2'd3;

  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_LOAD      = 4'd1;
  localparam logic [3:0] OP_SCAN      = 4'd2;
  localparam logic [3:0] OP_CLOSE     = 4'd3;
  localparam logic [3:0] OP_TAKE      = 4'd4;
  localparam logic [3:0] OP_WRITE     = 4'd5;
  localparam logic [3:0] OP_FREE_RD   = 4'd6;
  localparam logic [3:0] OP_FREE_CHK  = 4'd7;
  localparam logic [3:0] OP_LOWER_RD  = 4'd8;
  localparam logic [3:0] OP_LOWER_CHK = 4'd9;
  localparam logic [3:0] OP_OUT       = 4'd10;

  typedef struct packed {
    logic              func;
    logic [PN_W-1:0]   pages;
    logic [IDX_W-1:0]  page_index;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  first_page;
    logic [PN_W-1:0]   run_pages;
    logic [PN_W-1:0]   break_page;
  } rsp_t;

  typedef struct packed {
    logic [3:0] op;
    logic       set_status;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic zero_req;
    logic idx_ok;
    logic exact;
    logic scan_done;
    logic fit_any;
    logic head_ok;
    logic wr_last;
    logic brk_zero;
    logic q_zero;
  } sts_t;

endpackage

FILE: rtl/cpra_ctrl.sv
// Request sequencer of the page run allocator: scan, pick, write, free check and break lowering.
module cpra_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            slot_free,
  input  cpra_pkg::sts_t  sts,
  output logic            idle,
  output cpra_pkg::cmd_t  cmd
);
  import cpra_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_SCAN_END = 4'd3;
  localparam logic [3:0] S_PICK     = 4'd4;
  localparam logic [3:0] S_TAKE     = 4'd5;
  localparam logic [3:0] S_WRITE    = 4'd6;
  localparam logic [3:0] S_F_RD     = 4'd7;
  localparam logic [3:0] S_F_CHK    = 4'd8;
  localparam logic [3:0] S_L_RD     = 4'd9;
  localparam logic [3:0] S_L_CHK    = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign idle = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd.op         = OP_NONE;
    cmd.set_status = 1'b0;
    cmd.status     = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_free) begin
          if (sts.idx_ok) begin
            state_next = S_F_RD;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_BADFREE;
            state_next     = S_DONE;
          end
        end else if (sts.zero_req) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_ZERO;
          state_next     = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (sts.exact) begin
          state_next = S_PICK;
        end else if (sts.scan_done) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        cmd.op     = OP_CLOSE;
        state_next = S_PICK;
      end
      S_PICK: begin
        if (sts.fit_any) begin
          state_next = S_TAKE;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOSPACE;
          state_next     = S_DONE;
        end
      end
      S_TAKE: begin
        cmd.op     = OP_TAKE;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.op = OP_WRITE;
        if (sts.wr_last) begin
          if (sts.is_free) begin
            state_next = S_L_RD;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
            state_next     = S_DONE;
          end
        end
      end
      S_F_RD: begin
        cmd.op     = OP_FREE_RD;
        state_next = S_F_CHK;
      end
      S_F_CHK: begin
        cmd.op = OP_FREE_CHK;
        if (sts.head_ok) begin
          state_next = S_WRITE;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_BADFREE;
          state_next     = S_DONE;
        end
      end
      S_L_RD: begin
        cmd.op = OP_LOWER_RD;
        if (sts.brk_zero) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
          state_next     = S_DONE;
        end else begin
          state_next = S_L_CHK;
        end
      end
      S_L_CHK: begin
        cmd.op = OP_LOWER_CHK;
        if (sts.q_zero) begin
          state_next = S_L_RD;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
          state_next     = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/cpra_datapath.sv
// Page map memory, break, scan counters and run bookkeeping of the allocator.
module cpra_datapath #(
  parameter int PAGES = cpra_pkg::PAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cpra_pkg::req_t             req,
  input  cpra_pkg::cmd_t             cmd,
  input  logic [cpra_pkg::PN_W-1:0]  limit,
  output cpra_pkg::sts_t             sts,
  output cpra_pkg::rsp_t             result
);
  import cpra_pkg::*;

  localparam int AW = (PAGES > 1) ? $clog2(PAGES) : 1;

  logic [EW-1:0]    mem [PAGES];
  logic [EW-1:0]    q;

  logic             func_r;
  logic [PN_W-1:0]  n_r;
  logic [IDX_W-1:0] idx_r;
  logic [PN_W-1:0]  brk;
  logic [PN_W-1:0]  cnt;
  logic             pend;
  logic [PN_W-1:0]  pend_page;
  logic [PN_W-1:0]  run_start, run_len;
  logic [PN_W-1:0]  best_start, best_len;
  logic             exact;
  logic [PN_W-1:0]  exact_start;
  logic [PN_W-1:0]  target_start, target_len;
  logic [PN_W-1:0]  wr_page, wr_left;
  logic             wr_first, wr_zero;
  logic [1:0]       res_status;

  logic [PN_W-1:0]  lim_eff;
  logic [PN_W-1:0]  rd_page;
  logic [PN_W-1:0]  pick_start;
  logic [EW-1:0]    wr_data;
  logic             wr_en;
  logic             proc;
  logic             close_en;
  logic             fit_best, fit_ext;
  logic             res_ok;

  assign lim_eff = (32'(limit) < PAGES) ? limit : PN_W'(PAGES);

  assign fit_best = (best_len >= n_r);
  assign fit_ext  = (brk <= lim_eff) && (n_r <= lim_eff - brk);

  // A word is consumed only while no exact fit has been found yet.
  assign proc     = (cmd.op == OP_SCAN) && pend && !exact;
  assign close_en = (proc && (q != '0)) || (cmd.op == OP_CLOSE);

  assign pick_start = exact ? exact_start : (fit_best ? best_start : brk);

  always_comb begin
    case (cmd.op)
      OP_SCAN:    rd_page = cnt;
      OP_FREE_RD: rd_page = {1'b0, idx_r};
      default:    rd_page = brk - PN_W'(1);
    endcase
  end

  assign wr_en   = (cmd.op == OP_WRITE);
  assign wr_data = wr_zero ? '0 : (wr_first ? EW'(target_len) : CONT_MARK);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(wr_page)] <= wr_data;
    end
    q <= mem[AW'(rd_page)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brk   <= '0;
      pend  <= 1'b0;
      exact <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          func_r     <= req.func;
          n_r        <= req.pages;
          idx_r      <= req.page_index;
          cnt        <= '0;
          pend       <= 1'b0;
          run_start  <= '0;
          run_len    <= '0;
          best_start <= '0;
          best_len   <= '0;
          exact      <= 1'b0;
        end
        OP_SCAN: begin
          if (!exact && (cnt < brk)) begin
            cnt       <= cnt + PN_W'(1);
            pend      <= 1'b1;
            pend_page <= cnt;
          end else begin
            pend <= 1'b0;
          end
          if (proc) begin
            if (q == '0) begin
              if (run_len == '0) begin
                run_start <= pend_page;
              end
              run_len <= run_len + PN_W'(1);
            end else begin
              run_len <= '0;
            end
          end
        end
        OP_TAKE: begin
          target_start <= pick_start;
          target_len   <= n_r;
          wr_page      <= pick_start;
          wr_left      <= n_r;
          wr_first     <= 1'b1;
          wr_zero      <= 1'b0;
          if (!exact && !fit_best) begin
            brk <= brk + n_r;
          end
        end
        OP_WRITE: begin
          wr_page  <= wr_page + PN_W'(1);
          wr_left  <= wr_left - PN_W'(1);
          wr_first <= 1'b0;
        end
        OP_FREE_CHK: begin
          target_start <= {1'b0, idx_r};
          target_len   <= q[PN_W-1:0];
          wr_page      <= {1'b0, idx_r};
          wr_left      <= q[PN_W-1:0];
          wr_first     <= 1'b1;
          wr_zero      <= 1'b1;
        end
        OP_LOWER_CHK: begin
          if (q == '0) begin
            brk <= brk - PN_W'(1);
          end
        end
        default: begin
        end
      endcase

      // A free run ends at a used page or at the break.
      if (close_en && (run_len != '0)) begin
        if (run_len == n_r) begin
          exact       <= 1'b1;
          exact_start <= run_start;
        end else if (run_len > best_len) begin
          best_len   <= run_len;
          best_start <= run_start;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_status) begin
      res_status <= cmd.status;
    end
  end

  assign sts.is_free   = (func_r == FUNC_FREE);
  assign sts.zero_req  = (n_r == '0);
  assign sts.idx_ok    = ({1'b0, idx_r} < brk);
  assign sts.exact     = exact;
  assign sts.scan_done = !pend && (cnt >= brk);
  assign sts.fit_any   = exact || fit_best || fit_ext;
  assign sts.head_ok   = (q != '0) && (q != CONT_MARK);
  assign sts.wr_last   = (wr_left == PN_W'(1));
  assign sts.brk_zero  = (brk == '0);
  assign sts.q_zero    = (q == '0);

  assign res_ok            = (res_status == ST_OK);
  assign result.status     = res_status;
  assign result.first_page = res_ok ? target_start[IDX_W-1:0] : '0;
  assign result.run_pages  = res_ok ? target_len : '0;
  assign result.break_page = brk;

endmodule

FILE: rtl/contiguous_page_run_allocator.sv
// Top level of the contiguous page run allocator: APB register, result register, core.
// One request at a time. An allocate scans the pages below the break, one page per cycle,
// stopping at an exact fit, then writes the pages taken, one page per cycle. A free checks
// the run head, clears the run and then lowers the break past the free pages below it.
// The next request is taken the cycle after a result is registered, even while it is stalled.
// Synchronous reset sets the break to zero and the limit to 1024; the map needs no clearing.
module contiguous_page_run_allocator #(
  parameter int PAGES = cpra_pkg::PAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cpra_pkg::ADDR_W-1:0]  paddr,
  input  logic [cpra_pkg::DATA_W-1:0]  pwdata,
  output logic [cpra_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  cpra_pkg::req_t               req,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output cpra_pkg::rsp_t               rsp
);
  import cpra_pkg::*;

  logic [PN_W-1:0] limit;
  logic            idle;
  logic            start;
  logic            slot_free;
  cmd_t            cmd;
  sts_t            sts;
  rsp_t            result;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LIMIT)) begin
      limit <= pwdata[PN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_LIMIT) ? DATA_W'(limit) : '0;

  assign req_stall = !idle;
  assign start     = req_valid && idle;
  assign slot_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      rsp <= result;
    end
  end

  cpra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .slot_free (slot_free),
    .sts       (sts),
    .idle      (idle),
    .cmd       (cmd)
  );

  cpra_datapath #(
    .PAGES (PAGES)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .limit  (limit),
    .sts    (sts),
    .result (result)
  );

endmodule

FILE: rtl/cpra_checker.sv
// Port-level assertions for the page run allocator and the bind that attaches them.
module cpra_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_stall,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input cpra_pkg::rsp_t  rsp,
  input logic            pready
);
  import cpra_pkg::*;

  // A stalled result transfer holds its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed or dropped");

  // Requests are handled one at a time, so an accepted transfer closes the input.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("input open right after a request was taken");

  // A failed request reports no run.
  a_fail_no_run: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> (rsp.first_page == '0) && (rsp.run_pages == '0))
    else $error("failed request reports a run");

  // Every successful allocate or free moves at least one page.
  a_ok_nonempty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_OK) |-> (rsp.run_pages != '0))
    else $error("successful request with an empty run");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind contiguous_page_run_allocator cpra_checker u_cpra_checker (.*);

FILE: tb/tb_top.sv
// Self-checking bench for the contiguous page run allocator: directed table, then random traffic.
module tb_top;
  import cpra_pkg::*;

  localparam int PAGES       = PAGES_DEF;
  localparam int LIMIT_ADDR  = 4 * REG_LIMIT;
  localparam int SPARE_ADDR  = LIMIT_ADDR + 4;
  localparam int NPHASE      = 6;
  localparam int PHASE_ITEMS = 44;
  localparam int HOLD_CYCLES = 5000;
  localparam int WATCHDOG    = 40000;
  localparam int TAIL        = 3200;
  localparam int MAX_PRINTS  = 30;
  localparam int unsigned MAP_CONT = 32'hFFFF_FFFF;

  typedef struct packed {
    bit               cfg;    // row writes the limit register, value in pages
    bit               typed;  // expected reply is given in the row
    logic             func;
    logic [PN_W-1:0]  pages;
    logic [IDX_W-1:0] idx;
    logic [1:0]       st;
    logic [IDX_W-1:0] sp;
    logic [PN_W-1:0]  rp;
    logic [PN_W-1:0]  bk;
  } step_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              req_valid;
  logic              req_stall;
  req_t              req;
  logic              rsp_valid;
  logic              rsp_stall;
  rsp_t              rsp;

  // Software copy of the allocator state.
  int unsigned map_entry [PAGES];
  int unsigned heap_top;
  int unsigned limit_reg;
  int unsigned peak_top;
  rsp_t        pending_outcomes [$];

  int errors;
  int requests_sent;
  int replies_seen;
  int n_ok, n_nospace, n_badfree, n_zero;
  int holds_asked;
  bit sender_quiet;
  bit receiver_quiet;
  int phase_limits [NPHASE] = '{1024, 300, 1, 0, 2047, 64};
  step_t plan [$];

  contiguous_page_run_allocator #(.PAGES(PAGES)) DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report(input string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic void claim_run(int unsigned start, int unsigned n);
    for (int unsigned i = 0; i < n && start + i < PAGES; i++) map_entry[start + i] = MAP_CONT;
    if (start < PAGES) map_entry[start] = n;
  endfunction

  // Applies one request to the software state and returns the reply it must produce.
  function automatic rsp_t alloc_outcome(req_t r);
    rsp_t        o;
    int unsigned top, lim, n, idx, p, s, len, best_len, best_start;
    bit          done;
    o = '0;
    top = heap_top > PAGES ? PAGES : heap_top;
    n = r.pages;
    idx = r.page_index;
    if (r.func == FUNC_ALLOC) begin
      lim = limit_reg < PAGES ? limit_reg : PAGES;
      if (n == 0) begin
        o.status = ST_ZERO;
      end else begin
        p = 0;
        best_len = 0;
        best_start = 0;
        done = 1'b0;
        // Exact fit first, remembering the first of the longest free runs on the way.
        while (p < top && !done) begin
          if (map_entry[p] != 0) begin
            p++;
          end else begin
            s = p;
            while (p < top && map_entry[p] == 0) p++;
            len = p - s;
            if (len == n) begin
              claim_run(s, n);
              o.status = ST_OK;
              o.first_page = IDX_W'(s);
              o.run_pages = PN_W'(n);
              done = 1'b1;
            end else if (len > best_len) begin
              best_len = len;
              best_start = s;
            end
          end
        end
        if (!done) begin
          if (best_len >= n) begin
            claim_run(best_start, n);
            o.status = ST_OK;
            o.first_page = IDX_W'(best_start);
            o.run_pages = PN_W'(n);
          end else if (top <= lim && n <= lim - top) begin
            claim_run(top, n);
            heap_top = top + n;
            if (heap_top > peak_top) peak_top = heap_top;
            o.status = ST_OK;
            o.first_page = IDX_W'(top);
            o.run_pages = PN_W'(n);
          end else begin
            o.status = ST_NOSPACE;
          end
        end
      end
    end else begin
      if (idx >= top || map_entry[idx] == 0 || map_entry[idx] == MAP_CONT) begin
        o.status = ST_BADFREE;
      end else begin
        len = map_entry[idx];
        for (int unsigned i = 0; i < len && idx + i < PAGES; i++) map_entry[idx + i] = 0;
        while (top > 0 && map_entry[top - 1] == 0) top--;
        heap_top = top;
        o.status = ST_OK;
        o.first_page = IDX_W'(idx);
        o.run_pages = PN_W'(len);
      end
    end
    o.break_page = PN_W'(heap_top);
    return o;
  endfunction

  task automatic send_request(input req_t r, input bit typed, input rsp_t want);
    int   gap;
    rsp_t guess;
    gap = sender_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    guess = alloc_outcome(r);
    pending_outcomes.push_back(typed ? want : guess);
    requests_sent++;
    // The accepted request is withdrawn so that it is never offered twice.
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input int addr, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(addr);
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic reg_read(input int addr, output logic [DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_W'(addr);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    val = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic limit_readback();
    logic [DATA_W-1:0] got;
    reg_read(LIMIT_ADDR, got);
    if (got !== DATA_W'(limit_reg))
      report($sformatf("limit register reads %0d, expected %0d", got, limit_reg));
  endtask

  task automatic set_limit(input int val);
    wait_idle();
    reg_write(LIMIT_ADDR, DATA_W'(val));
    limit_reg = val & 32'h7FF;
    limit_readback();
  endtask

  // Reply side: checks every transfer and stalls at random, with one long hold on request.
  initial begin : reply_side
    rsp_t want;
    int   stall_left;
    int   holds_served;
    stall_left = 0;
    holds_served = 0;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        replies_seen++;
        if (pending_outcomes.size() == 0) begin
          report($sformatf("reply %0d arrived with no request outstanding", replies_seen));
        end else begin
          want = pending_outcomes.pop_front();
          if (rsp.status !== want.status)
            report($sformatf("reply %0d status %0d, expected %0d",
                             replies_seen, rsp.status, want.status));
          if (rsp.first_page !== want.first_page)
            report($sformatf("reply %0d first_page %0d, expected %0d",
                             replies_seen, rsp.first_page, want.first_page));
          if (rsp.run_pages !== want.run_pages)
            report($sformatf("reply %0d run_pages %0d, expected %0d",
                             replies_seen, rsp.run_pages, want.run_pages));
          if (rsp.break_page !== want.break_page)
            report($sformatf("reply %0d break_page %0d, expected %0d",
                             replies_seen, rsp.break_page, want.break_page));
        end
        case (rsp.status)
          ST_OK:      n_ok++;
          ST_NOSPACE: n_nospace++;
          ST_BADFREE: n_badfree++;
          default:    n_zero++;
        endcase
      end
      @(negedge clk);
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !receiver_quiet) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Timeout: no transfer in %0d cycles, %0d replies outstanding",
             WATCHDOG, pending_outcomes.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    req_t        r;
    rsp_t        want;
    int          pick;
    int          size;
    int unsigned heads [$];

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_valid = 1'b0;
    req = '0;
    for (int i = 0; i < PAGES; i++) map_entry[i] = 0;
    heap_top = 0;
    peak_top = 0;
    limit_reg = LIMIT_RESET;

    // Edge cases against an empty heap, the full heap, then hole reuse and break lowering.
    plan.push_back('{1'b0, 1'b1, FUNC_ALLOC, 11'd0, 10'd1023, ST_ZERO, 10'd0, 11'd0, 11'd0});
    plan.push_back('{1'b0, 1'b1, FUNC_ALLOC, 11'd2047, 10'd0, ST_NOSPACE, 10'd0, 11'd0, 11'd0});
    plan.push_back('{1'b0, 1'b1, FUNC_FREE, 11'd0, 10'd0, ST_BADFREE, 10'd0, 11'd0, 11'd0});
    plan.push_back('{1'b0, 1'b1, FUNC_ALLOC, 11'd1024, 10'd0, ST_OK, 10'd0, 11'd1024, 11'd1024});
    plan.push_back('{1'b0, 1'b1, FUNC_ALLOC, 11'd1, 10'd0, ST_NOSPACE, 10'd0, 11'd0, 11'd1024});
    plan.push_back('{1'b0, 1'b1, FUNC_FREE, 11'd2047, 10'd1023, ST_BADFREE, 10'd0, 11'd0,
                     11'd1024});
    plan.push_back('{1'b0, 1'b1, FUNC_FREE, 11'd0, 10'd0, ST_OK, 10'd0, 11'd1024, 11'd0});
    plan.push_back('{1'b0, 1'b0, FUNC_ALLOC, 11'd4, 10'd0, ST_OK, 10'd0, 11'd0, 11'd0});
    plan.push_back('{1'b0, 1'b0, FUNC_ALLOC, 11'd3, 10'd0, ST_OK, 10'd0, 11'd0, 11'd0});
    plan.push_back('{1'b0, 1'b0, FUNC_ALLOC, 11'd5, 10'd0, ST_OK, 10'd0, 11'd0, 11'd0});
    plan.push_back('{1'b0, 1'b0, FUNC_ALLOC, 11'd2, 10'd0, ST_OK, 10'd0, 11'd0, 11'd0});
    plan.push_back('{1'b0, 1'b0, FUNC_FREE, 11'd0, 10'd4, ST_OK, 10'd0, 11'd0, 11'd0});
    plan.push_back('{1'b0, 1'b0, FUNC_FREE, 11'd0, 10'd12, ST_OK, 10'd0, 11'd0, 11'd0});
    plan.push_back('{1'b0, 1'b0, FUNC_FREE, 11'd0, 10'd5, ST_OK, 10'd0, 11'd0, 11'd0});
    plan.push_back('{1'b0, 1'b0, FUNC_FREE, 11'd0, 10'd8, ST_OK, 10'd0, 11'd0, 11'd0});
    plan.push_back('{1'b0, 1'b0, FUNC_ALLOC, 11'd1, 10'd0, ST_OK, 10'd0, 11'd0, 11'd0});
    plan.push_back('{1'b0, 1'b0, FUNC_ALLOC, 11'd2, 10'd0, ST_OK, 10'd0, 11'd0, 11'd0});
    plan.push_back('{1'b0, 1'b0, FUNC_FREE, 11'd0, 10'd0, ST_OK, 10'd0, 11'd0, 11'd0});
    plan.push_back('{1'b0, 1'b0, FUNC_FREE, 11'd0, 10'd7, ST_OK, 10'd0, 11'd0, 11'd0});
    plan.push_back('{1'b0, 1'b0, FUNC_ALLOC, 11'd4, 10'd0, ST_OK, 10'd0, 11'd0, 11'd0});
    plan.push_back('{1'b0, 1'b0, FUNC_FREE, 11'd0, 10'd4, ST_OK, 10'd0, 11'd0, 11'd0});
    plan.push_back('{1'b0, 1'b0, FUNC_FREE, 11'd0, 10'd5, ST_OK, 10'd0, 11'd0, 11'd0});
    // With the limit under the break, nothing may extend the heap; once the break drops, the limit caps it.
    plan.push_back('{1'b1, 1'b0, FUNC_ALLOC, 11'd2, 10'd0, ST_OK, 10'd0, 11'd0, 11'd0});
    plan.push_back('{1'b0, 1'b1, FUNC_ALLOC, 11'd1, 10'd0, ST_NOSPACE, 10'd0, 11'd0, 11'd4});
    plan.push_back('{1'b0, 1'b1, FUNC_FREE, 11'd0, 10'd0, ST_OK, 10'd0, 11'd4, 11'd0});
    plan.push_back('{1'b0, 1'b1, FUNC_ALLOC, 11'd3, 10'd0, ST_NOSPACE, 10'd0, 11'd0, 11'd0});
    plan.push_back('{1'b0, 1'b1, FUNC_ALLOC, 11'd2, 10'd0, ST_OK, 10'd0, 11'd2, 11'd2});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    limit_readback();
    foreach (plan[k]) begin
      if (plan[k].cfg) begin
        set_limit(plan[k].pages);
      end else begin
        r.func = plan[k].func;
        r.pages = plan[k].pages;
        r.page_index = plan[k].idx;
        want.status = plan[k].st;
        want.first_page = plan[k].sp;
        want.run_pages = plan[k].rp;
        want.break_page = plan[k].bk;
        send_request(r, plan[k].typed, want);
      end
    end

    // A write to an address with no register behind it must leave the limit alone.
    wait_idle();
    reg_write(SPARE_ADDR, DATA_W'(5));
    limit_readback();

    for (int ph = 0; ph < NPHASE; ph++) begin
      set_limit(phase_limits[ph]);
      sender_quiet = (ph == 2);
      receiver_quiet = (ph == 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 0 && i == 8) holds_asked++;
        pick = $urandom_range(0, 99);
        r.pages = PN_W'($urandom);
        r.page_index = IDX_W'($urandom);
        heads.delete();
        for (int unsigned p = 0; p < heap_top; p++)
          if (map_entry[p] != 0 && map_entry[p] != MAP_CONT) heads.push_back(p);
        if (pick >= 55 && pick < 88 && heads.size() > 0) begin
          r.func = FUNC_FREE;
          r.page_index = IDX_W'(heads[$urandom_range(0, heads.size() - 1)]);
        end else if (pick < 88) begin
          // Mostly small runs keep the scans short; a few large ones stress the limit.
          pick = $urandom_range(0, 99);
          if (pick < 70) size = $urandom_range(1, 8);
          else if (pick < 92) size = $urandom_range(9, 40);
          else if (pick < 98) size = $urandom_range(41, 200);
          else size = $urandom_range(201, 1024);
          r.func = FUNC_ALLOC;
          r.pages = PN_W'(size);
        end else begin
          case ($urandom_range(0, 2))
            0: begin
              r.func = FUNC_ALLOC;
              r.pages = '0;
            end
            1: begin
              r.func = FUNC_ALLOC;
              r.pages = PN_W'($urandom_range(1025, 2047));
            end
            default: r.func = FUNC_FREE;
          endcase
        end
        send_request(r, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (TAIL) @(posedge clk);

    $display("Covered %0d requests: %0d granted, %0d out of space, %0d rejected frees, %0d %s",
             requests_sent, n_ok, n_nospace, n_badfree, n_zero, "zero-size.");
    $display("Swept %0d limit settings; the break peaked at %0d pages; %0d long reply hold(s).",
             NPHASE + 1, peak_top, holds_asked);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/cpra_pkg.sv
rtl/cpra_ctrl.sv
rtl/cpra_datapath.sv
rtl/contiguous_page_run_allocator.sv
rtl/cpra_checker.sv
tb/tb_top.sv
